FILE: design/sacla_pkg.sv
`timescale 1ns / 1ps

package sacla_pkg;

  localparam int unsigned SET_COUNT  = 128;
  localparam int unsigned WAY_COUNT  = 8;
  localparam int unsigned LINE_BYTES = 32;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OFF_W  = $clog2(LINE_BYTES);
  localparam int unsigned SET_W  = $clog2(SET_COUNT);
  localparam int unsigned WAY_W  = $clog2(WAY_COUNT);
  localparam int unsigned TAG_W  = ADDR_W - OFF_W - SET_W;
  // ages run from 0 (empty) up to WAY_COUNT
  localparam int unsigned AGE_W  = $clog2(WAY_COUNT + 1);

  localparam int unsigned DATA_ROWS = SET_COUNT * WAY_COUNT;
  localparam int unsigned LINE_W    = SET_W + WAY_W;

  typedef logic [WAY_COUNT-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAY_COUNT-1:0][AGE_W-1:0]  age_row_t;
  typedef logic [LINE_BYTES-1:0][BYTE_W-1:0] line_t;

  typedef struct packed {
    logic accept;   // latch item, read tag and age rows of its set
    logic lookup;   // resolve hit/victim, write back rows, access line
    logic clr_wr;   // clear one data line
    logic out_load; // load result register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

FILE: design/sacla_if.sv
`timescale 1ns / 1ps

interface sacla_req_if ();
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [sacla_pkg::ADDR_W-1:0]     address;
  logic [sacla_pkg::BYTE_W-1:0]     write_data;
  logic [sacla_pkg::BYTE_W-1:0]     fill_data;

  modport source (output valid, action, address, write_data, fill_data, input ready);
  modport sink   (input valid, action, address, write_data, fill_data, output ready);
endinterface

interface sacla_rsp_if ();
  logic                             valid;
  logic                             ready;
  logic [sacla_pkg::BYTE_W-1:0]     read_data;
  logic                             hit;
  logic [sacla_pkg::WAY_W-1:0]      way_used;

  modport source (output valid, read_data, hit, way_used, input ready);
  modport sink   (input valid, read_data, hit, way_used, output ready);
endinterface

FILE: design/sacla_ctrl.sv
`timescale 1ns / 1ps

module sacla_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  sacla_pkg::stat_t stat_i,
  output sacla_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    req_ready_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        // result leaves as the next item comes in
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          req_ready_o    = 1'b1;
          state_d        = req_valid_i ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    cmd_o.accept = req_ready_o && req_valid_i;
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

FILE: design/sacla_datapath.sv
`timescale 1ns / 1ps

module sacla_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sacla_pkg::cmd_t                cmd_i,
  output sacla_pkg::stat_t               stat_o,
  input  logic                           req_action_i,
  input  logic [sacla_pkg::ADDR_W-1:0]   req_address_i,
  input  logic [sacla_pkg::BYTE_W-1:0]   req_write_data_i,
  input  logic [sacla_pkg::BYTE_W-1:0]   req_fill_data_i,
  output logic [sacla_pkg::BYTE_W-1:0]   rsp_read_data_o,
  output logic                           rsp_hit_o,
  output logic [sacla_pkg::WAY_W-1:0]    rsp_way_used_o
);

  localparam int unsigned AGE_W = sacla_pkg::AGE_W;
  localparam int unsigned WAY_W = sacla_pkg::WAY_W;

  sacla_pkg::tag_row_t tag_mem  [sacla_pkg::SET_COUNT];
  sacla_pkg::age_row_t age_mem  [sacla_pkg::SET_COUNT];
  sacla_pkg::line_t    data_mem [sacla_pkg::DATA_ROWS];

  logic [sacla_pkg::SET_COUNT-1:0] age_vld_q;
  logic [sacla_pkg::LINE_W-1:0]    clr_cnt_q;

  logic                          act_q;
  logic [sacla_pkg::TAG_W-1:0]   tag_q;
  logic [sacla_pkg::SET_W-1:0]   set_q;
  logic [sacla_pkg::OFF_W-1:0]   off_q;
  logic [sacla_pkg::BYTE_W-1:0]  wdata_q;
  logic [sacla_pkg::BYTE_W-1:0]  fdata_q;

  sacla_pkg::tag_row_t tag_rd_q;
  sacla_pkg::age_row_t age_rd_q;
  logic                age_rv_q;
  logic [sacla_pkg::BYTE_W-1:0] byte_rd_q;
  logic                hit_q;
  logic [WAY_W-1:0]    way_q;

  sacla_pkg::age_row_t ages, ages_new;
  sacla_pkg::tag_row_t tags_new;
  logic                hit;
  logic [WAY_W-1:0]    hit_way, empty_way, old_way, way;
  logic                empty_found;
  logic [AGE_W-1:0]    oldest, prior_age;
  logic [sacla_pkg::LINE_W-1:0] line_idx;
  logic                data_wr;

  // a set whose row was never written has all ways empty
  assign ages = age_rv_q ? age_rd_q : '0;

  always_comb begin
    hit         = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    oldest      = '0;
    old_way     = '0;
    for (int w = 0; w < sacla_pkg::WAY_COUNT; w++) begin
      if (ages[w] != '0 && tag_rd_q[w] == tag_q) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!empty_found && ages[w] == '0) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(w);
      end
      if (ages[w] > oldest) begin
        oldest  = ages[w];
        old_way = WAY_W'(w);
      end
    end
    way = hit ? hit_way : (empty_found ? empty_way : old_way);
  end

  // used way becomes most recent; younger non-empty ways age by one
  always_comb begin
    prior_age = ages[way];
    ages_new  = ages;
    for (int w = 0; w < sacla_pkg::WAY_COUNT; w++) begin
      if (WAY_W'(w) == way) begin
        ages_new[w] = AGE_W'(1);
      end else if (ages[w] == '0 || (prior_age != '0 && ages[w] >= prior_age)) begin
        ages_new[w] = ages[w];
      end else begin
        ages_new[w] = ages[w] + AGE_W'(1);
      end
    end
    tags_new = tag_rd_q;
    if (!hit) tags_new[way] = tag_q;
  end

  assign line_idx = {set_q, way};
  assign data_wr  = act_q || !hit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tag_rd_q <= tag_mem[req_address_i[sacla_pkg::OFF_W +: sacla_pkg::SET_W]];
      age_rd_q <= age_mem[req_address_i[sacla_pkg::OFF_W +: sacla_pkg::SET_W]];
    end
    if (cmd_i.lookup) begin
      tag_mem[set_q] <= tags_new;
      age_mem[set_q] <= ages_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      data_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.lookup && data_wr) begin
      data_mem[line_idx][off_q] <= act_q ? wdata_q : fdata_q;
    end
    if (cmd_i.lookup && !data_wr) begin
      byte_rd_q <= data_mem[line_idx][off_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_vld_q <= '0;
      clr_cnt_q <= '0;
      age_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + sacla_pkg::LINE_W'(1);
      if (cmd_i.accept) begin
        age_rv_q <= age_vld_q[req_address_i[sacla_pkg::OFF_W +: sacla_pkg::SET_W]];
      end
      if (cmd_i.lookup) age_vld_q[set_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q   <= req_action_i;
      off_q   <= req_address_i[sacla_pkg::OFF_W-1:0];
      set_q   <= req_address_i[sacla_pkg::OFF_W +: sacla_pkg::SET_W];
      tag_q   <= req_address_i[sacla_pkg::ADDR_W-1 -: sacla_pkg::TAG_W];
      wdata_q <= req_write_data_i;
      fdata_q <= req_fill_data_i;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit;
      way_q <= way;
    end
    if (cmd_i.out_load) begin
      // a read miss returns the byte just filled
      rsp_read_data_o <= act_q ? '0 : (hit_q ? byte_rd_q : fdata_q);
      rsp_hit_o       <= hit_q;
      rsp_way_used_o  <= way_q;
    end
  end

  assign stat_o.clr_last = (clr_cnt_q == sacla_pkg::LINE_W'(sacla_pkg::DATA_ROWS - 1));

endmodule

FILE: design/set_assoc_cache_lru_age_core.sv
// Flow: an accepted item passes from ST_LOOKUP to ST_RESP, where its result is
// loaded once the result register is free; a new item is taken only then, as
// set by the read and write-back of tag and age rows in the synchronous memories.
// Reset: ages clear at once through per-set valid flops; the data store is then
// swept one line per cycle, all 1024 lines, with req.ready low until it is done.
`timescale 1ns / 1ps

module set_assoc_cache_lru_age_core (
  input logic         clk_i,
  input logic         rst_ni,
  sacla_req_if.sink   req,
  sacla_rsp_if.source rsp
);

  sacla_pkg::cmd_t  cmd;
  sacla_pkg::stat_t stat;

  sacla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sacla_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_action_i     (req.action),
    .req_address_i    (req.address),
    .req_write_data_i (req.write_data),
    .req_fill_data_i  (req.fill_data),
    .rsp_read_data_o  (rsp.read_data),
    .rsp_hit_o        (rsp.hit),
    .rsp_way_used_o   (rsp.way_used)
  );

  a_accept_then_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> cmd.lookup)
    else $error("accepted item not looked up in next cycle");

  a_load_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten while full");

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !req.ready)
    else $error("item accepted during data clear");

  a_lookup_then_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.lookup |=> !cmd.lookup)
    else $error("back-to-back lookups");

endmodule
